FILE: src/smid_pkg.sv
package smid_pkg;

	localparam int CAPACITY    = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [5:0]         count;
		logic [1:0]         status;
		logic               last;
	} out_t;

	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_LOAD = 3'd1,
		CELL_INS  = 3'd2,
		CELL_DEL  = 3'd3,
		CELL_ROT  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] value;
		logic [CNT_W-1:0]   count;
	} cell_ctl_t;

endpackage

FILE: src/smid_cell.sv
module smid_cell (
	input  logic                         clk,
	input  smid_pkg::cell_ctl_t          ctl,
	input  logic [smid_pkg::IDX_W-1:0]   idx,
	input  logic signed [31:0]           left_entry,
	input  logic                         left_ins,
	input  logic signed [31:0]           right_entry,
	input  logic signed [31:0]           head_entry,
	output logic signed [31:0]           entry,
	output logic                         ins_flag,
	output logic                         eq_flag
);

	logic signed [31:0] entry_q;
	logic               ins_q;
	logic               del_q;
	logic               eq_q;
	logic               occ;
	logic               at_cnt;
	logic               tail;

	assign occ    = smid_pkg::CNT_W'(idx) < ctl.count;
	assign at_cnt = smid_pkg::CNT_W'(idx) == ctl.count;
	assign tail   = smid_pkg::CNT_W'(idx) == (ctl.count - smid_pkg::CNT_W'(1));

	// flags are captured at the accept edge (CELL_LOAD); entries move on a later CELL_INS, CELL_DEL or CELL_ROT command
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			smid_pkg::CELL_HOLD: begin
			end
			smid_pkg::CELL_LOAD: begin
				ins_q <= at_cnt || (occ && (ctl.value < entry_q));
				del_q <= occ && (ctl.value <= entry_q);
				eq_q  <= occ && (ctl.value == entry_q);
			end
			smid_pkg::CELL_INS: begin
				if (ins_q) begin
					entry_q <= left_ins ? left_entry : ctl.value;
				end
			end
			smid_pkg::CELL_DEL: begin
				if (del_q) begin
					entry_q <= right_entry;
				end
			end
			smid_pkg::CELL_ROT: begin
				entry_q <= tail ? head_entry : right_entry;
			end
			default: begin
			end
		endcase
	end

	assign entry    = entry_q;
	assign ins_flag = ins_q;
	assign eq_flag  = eq_q;

endmodule

FILE: src/sorted_multiset_insert_delete.sv
// Sorted multiset store: keeps up to CAPACITY signed 32-bit values in
// ascending order in a row of cells, plus an entry count.
// Command channel: item (opcode, value) transfers at a rising edge with
// start high and busy low. Result channel: result is valid for exactly one
// cycle while done is high; the receiver cannot stall it.
// Insert / delete: every cell compares the operand at the accept edge, and
// on the next edge the cells shift one place toward or away from the
// insertion or deletion point. The result strobe is registered from the EXEC
// state; busy stays high through EXEC, so no new item is taken there.
// Full insert and empty dump answer straight from idle without going busy.
// Dump: the occupied cells rotate left once per cycle, cell 0 presenting
// each entry in turn; a result is sent when the entry differs from its right
// neighbor (end of a run of equal values) or is the last occupied entry, so
// distinct values stream one per run, last marks the final one. A dump
// holds busy until each entry has passed cell 0; the store ends as it was.
// Reset (arst_n low) empties the store and clears any pending result;
// entry contents are not cleared, only the count.
module sorted_multiset_insert_delete (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  smid_pkg::in_t  item,
	output logic           done,
	output smid_pkg::out_t result
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DUMP = 3'b100
	} state_t;

	state_t                         state_q;
	logic [smid_pkg::CNT_W-1:0]     count_q;
	logic [1:0]                     op_q;
	logic signed [31:0]             v_q;
	logic [smid_pkg::IDX_W-1:0]     j_q;
	logic [smid_pkg::RES_W-1:0]     k_q;
	logic                           done_q;
	smid_pkg::out_t                 result_q;

	smid_pkg::cell_ctl_t            ctl;
	logic signed [31:0]             e_w [smid_pkg::CAPACITY];
	logic [smid_pkg::CAPACITY-1:0]  ins_w;
	logic [smid_pkg::CAPACITY-1:0]  eq_w;

	logic accept;
	logic found;
	logic is_ins;
	logic j_at_tail;
	logic emit;
	logic dump_last;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign found  = |eq_w;
	assign is_ins = op_q == smid_pkg::OP_INSERT;

	// dump walk: j counts rotations, k counts results sent
	assign j_at_tail = smid_pkg::CNT_W'(j_q) == (count_q - smid_pkg::CNT_W'(1));
	assign emit      = (j_at_tail || (e_w[0] != e_w[1]))
	                   && (k_q < smid_pkg::RES_W'(smid_pkg::MAX_RESULTS));
	assign dump_last = j_at_tail || (k_q == smid_pkg::RES_W'(smid_pkg::MAX_RESULTS - 1));

	// cell command: compare on accept, then shift or rotate
	always_comb begin
		ctl.count = count_q;
		ctl.value = (state_q == S_IDLE) ? item.value : v_q;
		unique case (state_q)
			S_IDLE: ctl.op = accept ? smid_pkg::CELL_LOAD : smid_pkg::CELL_HOLD;
			S_EXEC: begin
				if (is_ins) begin
					ctl.op = smid_pkg::CELL_INS;
				end else begin
					ctl.op = found ? smid_pkg::CELL_DEL : smid_pkg::CELL_HOLD;
				end
			end
			S_DUMP:  ctl.op = smid_pkg::CELL_ROT;
			default: ctl.op = smid_pkg::CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < smid_pkg::CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_e;
		logic               left_f;
		logic signed [31:0] right_e;

		if (i == 0) begin : g_first
			assign left_e = e_w[i];
			assign left_f = 1'b0;
		end else begin : g_mid
			assign left_e = e_w[i-1];
			assign left_f = ins_w[i-1];
		end
		// last cell's right side only feeds slots beyond the count
		if (i == smid_pkg::CAPACITY - 1) begin : g_last
			assign right_e = e_w[i];
		end else begin : g_inner
			assign right_e = e_w[i+1];
		end

		smid_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.idx         (smid_pkg::IDX_W'(i)),
			.left_entry  (left_e),
			.left_ins    (left_f),
			.right_entry (right_e),
			.head_entry  (e_w[0]),
			.entry       (e_w[i]),
			.ins_flag    (ins_w[i]),
			.eq_flag     (eq_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			j_q     <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= item.opcode;
						v_q  <= item.value;
						if (item.opcode[1]) begin
							if (count_q == '0) begin
								done_q             <= 1'b1;
								result_q.out_value <= '0;
								result_q.count     <= '0;
								result_q.status    <= smid_pkg::ST_EMPTY;
								result_q.last      <= 1'b1;
							end else begin
								state_q <= S_DUMP;
								j_q     <= '0;
								k_q     <= '0;
							end
						end else if (item.opcode == smid_pkg::OP_INSERT &&
						             count_q >= smid_pkg::CNT_W'(smid_pkg::CAPACITY)) begin
							done_q             <= 1'b1;
							result_q.out_value <= item.value;
							result_q.count     <= 6'(count_q);
							result_q.status    <= smid_pkg::ST_FULL;
							result_q.last      <= 1'b1;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					state_q            <= S_IDLE;
					done_q             <= 1'b1;
					result_q.out_value <= v_q;
					result_q.last      <= 1'b1;
					if (is_ins) begin
						count_q         <= count_q + smid_pkg::CNT_W'(1);
						result_q.count  <= 6'(count_q + smid_pkg::CNT_W'(1));
						result_q.status <= smid_pkg::ST_OK;
					end else if (found) begin
						count_q         <= count_q - smid_pkg::CNT_W'(1);
						result_q.count  <= 6'(count_q - smid_pkg::CNT_W'(1));
						result_q.status <= smid_pkg::ST_OK;
					end else begin
						result_q.count  <= 6'(count_q);
						result_q.status <= smid_pkg::ST_NOT_FOUND;
					end
				end
				S_DUMP: begin
					if (emit) begin
						done_q             <= 1'b1;
						result_q.out_value <= e_w[0];
						result_q.count     <= 6'(count_q);
						result_q.status    <= smid_pkg::ST_OK;
						result_q.last      <= dump_last;
						k_q                <= k_q + smid_pkg::RES_W'(1);
					end
					j_q <= j_q + smid_pkg::IDX_W'(1);
					if (j_at_tail) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// ---- assertions ----
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smid_pkg::CNT_W'(smid_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == smid_pkg::ST_FULL)
		|-> count_q == smid_pkg::CNT_W'(smid_pkg::CAPACITY))
		else $error("full status reported while store has room");

	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_IDLE && done))
		else $error("insert/delete did not finish in one busy cycle");

	a_ins_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.opcode == smid_pkg::OP_INSERT &&
		 count_q < smid_pkg::CNT_W'(smid_pkg::CAPACITY))
		|-> ##2 (done && result.status == smid_pkg::ST_OK && result.last))
		else $error("insert result missing");

endmodule
